### rtl/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block
`timescale 1ns / 1ps
package ps2mc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned DX_W      = 9;
    localparam int unsigned DY_W      = 10;
    localparam int unsigned BTN_W     = 2;
    localparam int unsigned SUM_W     = POS_W + 2;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] X_LIMIT_RESET = POS_W'(320 - 16);
    localparam logic [POS_W-1:0] Y_LIMIT_RESET = POS_W'(200 - 16);
    localparam logic [POS_W-1:0] POS_RESET     = POS_W'(40);

    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 2'd1;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 2'd2;
    localparam logic [BTN_W-1:0] BTN_MIDDLE = 2'd3;

    localparam int unsigned BIT_LEFT   = 0;
    localparam int unsigned BIT_RIGHT  = 1;
    localparam int unsigned BIT_MIDDLE = 2;
    localparam int unsigned BIT_XSIGN  = 4;
    localparam int unsigned BIT_YSIGN  = 5;

    typedef enum logic [1:0] {
        PH_ACK    = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_THIRD  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] third;
    } packet_t;

    typedef struct packed {
        logic    push;
        packet_t pkt;
    } push_t;

endpackage

### rtl/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet decoder with clamped cursor
`timescale 1ns / 1ps
// Usage:
//   in channel (in_valid/in_ready/in_byte): one raw mouse byte per item.
//   The first item after reset is the device acknowledge and is dropped;
//   after that every three items form one packet.
//   out channel (out_valid/out_ready/...): one item per completed packet,
//   carrying button, delta_x, delta_y and the new clamped cursor position.
//   A packet's third byte enters the packet queue; the packet then moves to the
//   output register when it is free. Throughput: one byte per cycle while the
//   queue is not full, set by the back-end add-and-clamp and the two-entry queue.
//   APB port: x_limit at address 0, y_limit at address 4, 12 bits each;
//   write only while no packet is in flight.
//   Reset: phase returns to awaiting acknowledge, cursor to (40,40),
//   limits to 304 and 184; queue and output register are emptied.
//   Receiver stall: the output item holds, the packet queue fills, and
//   in_ready drops once the queue is full; no item is lost.
module ps2_mouse_packet_cursor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]       in_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ps2mc_pkg::BTN_W-1:0]        button,
    output logic signed [ps2mc_pkg::DX_W-1:0]  delta_x,
    output logic signed [ps2mc_pkg::DY_W-1:0]  delta_y,
    output logic [ps2mc_pkg::POS_W-1:0]        cursor_x,
    output logic [ps2mc_pkg::POS_W-1:0]        cursor_y,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ps2mc_pkg::APB_AW-1:0]       paddr,
    input  logic [ps2mc_pkg::APB_DW-1:0]       pwdata,
    output logic [ps2mc_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import ps2mc_pkg::*;

    logic [POS_W-1:0] x_limit_reg;
    logic [POS_W-1:0] y_limit_reg;
    logic             cfg_we;
    logic             reg_idx;
    push_t            push;
    packet_t          head;
    logic             fifo_full;
    logic             fifo_empty;
    logic             pop;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_X_LIMIT: x_limit_reg <= pwdata[POS_W-1:0];
                REG_Y_LIMIT: y_limit_reg <= pwdata[POS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_X_LIMIT: prdata = {{(APB_DW - POS_W){1'b0}}, x_limit_reg};
            REG_Y_LIMIT: prdata = {{(APB_DW - POS_W){1'b0}}, y_limit_reg};
            default:     prdata = '0;
        endcase
    end

    ps2mc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .fifo_full (fifo_full),
        .push_o    (push)
    );

    ps2mc_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .head   (head),
        .empty  (fifo_empty),
        .full   (fifo_full)
    );

    ps2mc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .x_limit    (x_limit_reg),
        .y_limit    (y_limit_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .button     (button),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .cursor_x   (cursor_x),
        .cursor_y   (cursor_y)
    );

endmodule

### rtl/ps2mc_front.sv
// Byte framing: skip the acknowledge, gather three-byte packets
`timescale 1ns / 1ps
module ps2mc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0] in_byte,
    input  logic                        fifo_full,
    output ps2mc_pkg::push_t            push_o
);
    import ps2mc_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] first_next;
    logic [BYTE_W-1:0] second_reg;
    logic [BYTE_W-1:0] second_next;
    logic              accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ACK:    phase_next = PH_FIRST;
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_THIRD;
                PH_THIRD:  phase_next = PH_FIRST;
                default:   phase_next = PH_ACK;
            endcase
        end
    end

    always_comb
    begin
        first_next      = first_reg;
        second_next     = second_reg;
        push_o.push     = 1'b0;
        push_o.pkt      = '{first: first_reg, second: second_reg, third: in_byte};
        if (accept)
        begin
            unique case (phase_reg)
                PH_ACK:    ;
                PH_FIRST:  first_next  = in_byte;
                PH_SECOND: second_next = in_byte;
                PH_THIRD:  push_o.push = 1'b1;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ACK;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

### rtl/ps2mc_fifo.sv
// Two-entry packet queue between framing and cursor update
`timescale 1ns / 1ps
module ps2mc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  ps2mc_pkg::push_t   push_i,
    input  logic               pop,
    output ps2mc_pkg::packet_t head,
    output logic               empty,
    output logic               full
);
    import ps2mc_pkg::*;

    packet_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   wr_ptr_reg;
    logic [FIFO_PW-1:0]   wr_ptr_next;
    logic [FIFO_PW-1:0]   rd_ptr_reg;
    logic [FIFO_PW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign do_push = push_i.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_i.pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/ps2mc_back.sv
// Packet decode, cursor add and clamp, output register
`timescale 1ns / 1ps
module ps2mc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ps2mc_pkg::packet_t                head,
    input  logic                              fifo_empty,
    output logic                              pop,
    input  logic [ps2mc_pkg::POS_W-1:0]       x_limit,
    input  logic [ps2mc_pkg::POS_W-1:0]       y_limit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ps2mc_pkg::BTN_W-1:0]       button,
    output logic signed [ps2mc_pkg::DX_W-1:0] delta_x,
    output logic signed [ps2mc_pkg::DY_W-1:0] delta_y,
    output logic [ps2mc_pkg::POS_W-1:0]       cursor_x,
    output logic [ps2mc_pkg::POS_W-1:0]       cursor_y
);
    import ps2mc_pkg::*;

    function automatic logic [POS_W-1:0] clamp(input logic [SUM_W-1:0] sum,
                                               input logic [POS_W-1:0] limit);
        logic [POS_W-1:0] res;
        if (sum[SUM_W-1])
        begin
            res = '0;
        end
        else if (sum[SUM_W-2:0] > {1'b0, limit})
        begin
            res = limit;
        end
        else
        begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

    logic                     out_valid_reg;
    logic [BTN_W-1:0]         button_reg;
    logic [BTN_W-1:0]         button_next;
    logic [DX_W-1:0]          delta_x_reg;
    logic [DX_W-1:0]          delta_x_next;
    logic [DY_W-1:0]          delta_y_reg;
    logic [DY_W-1:0]          delta_y_next;
    logic [POS_W-1:0]         pos_x_reg;
    logic [POS_W-1:0]         pos_x_next;
    logic [POS_W-1:0]         pos_y_reg;
    logic [POS_W-1:0]         pos_y_next;
    logic [DX_W-1:0]          dy_raw;
    logic [SUM_W-1:0]         sum_x;
    logic [SUM_W-1:0]         sum_y;

    assign pop = !fifo_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        priority if (head.first[BIT_LEFT])
        begin
            button_next = BTN_LEFT;
        end
        else if (head.first[BIT_RIGHT])
        begin
            button_next = BTN_RIGHT;
        end
        else if (head.first[BIT_MIDDLE])
        begin
            button_next = BTN_MIDDLE;
        end
        else
        begin
            button_next = BTN_NONE;
        end
    end

    always_comb
    begin
        delta_x_next = {head.first[BIT_XSIGN], head.second};
        dy_raw       = {head.first[BIT_YSIGN], head.third};
        delta_y_next = DY_W'(0) - {dy_raw[DX_W-1], dy_raw};
        sum_x        = {2'b00, pos_x_reg}
                     + {{(SUM_W - DX_W){delta_x_next[DX_W-1]}}, delta_x_next};
        sum_y        = {2'b00, pos_y_reg}
                     + {{(SUM_W - DY_W){delta_y_next[DY_W-1]}}, delta_y_next};
        pos_x_next   = clamp(sum_x, x_limit);
        pos_y_next   = clamp(sum_y, y_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_x_reg     <= POS_RESET;
            pos_y_reg     <= POS_RESET;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            button_reg  <= button_next;
            delta_x_reg <= delta_x_next;
            delta_y_reg <= delta_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign button    = button_reg;
    assign delta_x   = $signed(delta_x_reg);
    assign delta_y   = $signed(delta_y_reg);
    assign cursor_x  = pos_x_reg;
    assign cursor_y  = pos_y_reg;

endmodule

### rtl/ps2mc_checker.sv
// Port-level assertions for the PS/2 mouse packet cursor, bound to the top level
`timescale 1ns / 1ps
module ps2mc_assertions (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [ps2mc_pkg::BTN_W-1:0]        button,
    input logic signed [ps2mc_pkg::DX_W-1:0]  delta_x,
    input logic signed [ps2mc_pkg::DY_W-1:0]  delta_y,
    input logic [ps2mc_pkg::POS_W-1:0]        cursor_x,
    input logic [ps2mc_pkg::POS_W-1:0]        cursor_y,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [ps2mc_pkg::APB_AW-1:0]       paddr,
    input logic [ps2mc_pkg::APB_DW-1:0]       pwdata,
    input logic                               pready
);
    import ps2mc_pkg::*;

    logic [POS_W-1:0] x_lim;
    logic [POS_W-1:0] y_lim;
    logic             cfg_x;
    logic             cfg_y;

    assign cfg_x = psel && penable && pwrite && pready && (paddr[2] == REG_X_LIMIT);
    assign cfg_y = psel && penable && pwrite && pready && (paddr[2] == REG_Y_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lim <= X_LIMIT_RESET;
            y_lim <= Y_LIMIT_RESET;
        end
        else
        begin
            if (cfg_x)
            begin
                x_lim <= pwdata[POS_W-1:0];
            end
            if (cfg_y)
            begin
                y_lim <= pwdata[POS_W-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
                                    && $stable(button) && $stable(delta_x)
                                    && $stable(delta_y))
        else $error("result item changed while stalled");

    a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_x <= x_lim)
        else $error("cursor_x beyond x_limit");

    a_y_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_y <= y_lim)
        else $error("cursor_y beyond y_limit");

    a_result_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result item appeared without a closing byte");

endmodule

bind ps2_mouse_packet_cursor ps2mc_assertions u_ps2mc_assertions (.*);

### tb/ps2mc_checker.sv
// Checker that predicts and compares the cursor items of the PS/2 mouse packet block
`timescale 1ns / 1ps
module ps2mc_checker
    import ps2mc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [BYTE_W-1:0]        in_byte,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [BTN_W-1:0]         button,
    input  logic signed [DX_W-1:0]   delta_x,
    input  logic signed [DY_W-1:0]   delta_y,
    input  logic [POS_W-1:0]         cursor_x,
    input  logic [POS_W-1:0]         cursor_y,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    input  logic                     pready,
    input  logic                     drain_done,
    output int                       fail_count,
    output int                       pending,
    output int                       bytes_seen,
    output int                       packets_seen,
    output int                       floor_hits,
    output int                       ceil_hits
);

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic [DX_W-1:0]  dx;
        logic [DY_W-1:0]  dy;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
    } motion_t;

    motion_t          motion_q[$];
    phase_t           phase;
    logic [BYTE_W-1:0] first_b;
    logic [BYTE_W-1:0] second_b;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] x_lim;
    logic [POS_W-1:0] y_lim;
    logic             drained;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
                                                    input int delta,
                                                    input logic [POS_W-1:0] lim);
        int s;
        s = int'(pos) + delta;
        if (s < 0)
        begin
            s = 0;
            floor_hits++;
        end
        if (s > int'(lim))
        begin
            s = int'(lim);
            ceil_hits++;
        end
        return s[POS_W-1:0];
    endfunction

    task automatic take_byte(input logic [BYTE_W-1:0] b);
        motion_t m;
        int      dx;
        int      dy;
        case (phase)
            PH_ACK:
            begin
                phase = PH_FIRST;
            end
            PH_FIRST:
            begin
                first_b = b;
                phase = PH_SECOND;
            end
            PH_SECOND:
            begin
                second_b = b;
                phase = PH_THIRD;
            end
            default:
            begin
                phase = PH_FIRST;
                if (first_b[BIT_LEFT])
                    m.btn = BTN_LEFT;
                else if (first_b[BIT_RIGHT])
                    m.btn = BTN_RIGHT;
                else if (first_b[BIT_MIDDLE])
                    m.btn = BTN_MIDDLE;
                else
                    m.btn = BTN_NONE;
                dx = int'(second_b) - (first_b[BIT_XSIGN] ? 256 : 0);
                dy = (first_b[BIT_YSIGN] ? 256 : 0) - int'(b);
                pos_x = clamp_axis(pos_x, dx, x_lim);
                pos_y = clamp_axis(pos_y, dy, y_lim);
                m.dx = dx[DX_W-1:0];
                m.dy = dy[DY_W-1:0];
                m.cx = pos_x;
                m.cy = pos_y;
                motion_q.push_back(m);
                packets_seen++;
            end
        endcase
    endtask

    task automatic check_motion();
        motion_t m;
        if (motion_q.size() == 0)
        begin
            report($sformatf("item with nothing pending: button %0d cursor (%0d,%0d)",
                             button, cursor_x, cursor_y));
            return;
        end
        m = motion_q.pop_front();
        if (button !== m.btn)
            report($sformatf("button got %0d want %0d", button, m.btn));
        if (delta_x !== m.dx)
            report($sformatf("delta_x got %0d want %0d", delta_x, $signed(m.dx)));
        if (delta_y !== m.dy)
            report($sformatf("delta_y got %0d want %0d", delta_y, $signed(m.dy)));
        if (cursor_x !== m.cx)
            report($sformatf("cursor_x got %0d want %0d", cursor_x, m.cx));
        if (cursor_y !== m.cy)
            report($sformatf("cursor_y got %0d want %0d", cursor_y, m.cy));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_ACK;
            first_b = '0;
            second_b = '0;
            pos_x = POS_RESET;
            pos_y = POS_RESET;
            x_lim = X_LIMIT_RESET;
            y_lim = Y_LIMIT_RESET;
            drained = 1'b0;
            motion_q.delete();
            fail_count = 0;
            bytes_seen = 0;
            packets_seen = 0;
            floor_hits = 0;
            ceil_hits = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_AW-1] == REG_X_LIMIT)
                    x_lim = pwdata[POS_W-1:0];
                else
                    y_lim = pwdata[POS_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                bytes_seen++;
                take_byte(in_byte);
            end
            if (out_valid && out_ready)
                check_motion();
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                while (motion_q.size() != 0)
                begin
                    report($sformatf("packet never delivered: cursor (%0d,%0d)",
                                     motion_q[0].cx, motion_q[0].cy));
                    void'(motion_q.pop_front());
                end
            end
            pending <= motion_q.size();
        end
    end

endmodule

### tb/tb_ps2_mouse_packet_cursor.sv
// Testbench top for the PS/2 mouse packet cursor block: stimulus, register writes and verdict
`timescale 1ns / 1ps
module tb_ps2_mouse_packet_cursor;
    import ps2mc_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int PHASE_BYTES = 90;
    localparam int N_SETTINGS  = 6;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_LONG
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BTN_W-1:0]    button;
    logic signed [DX_W-1:0] delta_x;
    logic signed [DY_W-1:0] delta_y;
    logic [POS_W-1:0]    cursor_x;
    logic [POS_W-1:0]    cursor_y;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                drain_done = 1'b0;

    int fail_count;
    int pending;
    int bytes_seen;
    int packets_seen;
    int floor_hits;
    int ceil_hits;
    int burst_left = 0;
    int settings_used = 1;
    int cycles = 0;

    rx_mode_t   rx_mode = RX_OPEN;
    int         mode_left = 0;
    logic [4:0] tick = '0;

    logic [BYTE_W-1:0] opening [22] = '{
        8'hFA,
        8'h08, 8'h00, 8'h00,
        8'h09, 8'h7F, 8'h80,
        8'h3A, 8'h00, 8'h00,
        8'h04, 8'hFF, 8'hFF,
        8'h07, 8'h55, 8'hAA,
        8'h06, 8'hAA, 8'h55,
        8'hFF, 8'hFF, 8'hFF
    };
    logic [POS_W-1:0] x_setting [N_SETTINGS] = '{12'd4095, 12'd9, 12'd0, 12'd0, 12'd4095, 12'd304};
    logic [POS_W-1:0] y_setting [N_SETTINGS] = '{12'd4095, 12'd5, 12'd0, 12'd0, 12'd0, 12'd184};

    ps2_mouse_packet_cursor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .button    (button),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .cursor_x  (cursor_x),
        .cursor_y  (cursor_y),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    ps2mc_checker packet_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button       (button),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .drain_done   (drain_done),
        .fail_count   (fail_count),
        .pending      (pending),
        .bytes_seen   (bytes_seen),
        .packets_seen (packets_seen),
        .floor_hits   (floor_hits),
        .ceil_hits    (ceil_hits)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 160);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        tick <= tick + 1'b1;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (tick[1:0] == 2'd0);
            default:   out_ready <= (tick >= 5'd22);
        endcase
    end

    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d packets still pending", cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return BYTE_W'($urandom_range(0, 255));
            6:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            7:       return $urandom_range(0, 1) ? 8'h7F : 8'h80;
            default: return BYTE_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap_len;
        if (burst_left == 0)
        begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 60);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic sel, input logic [POS_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({sel, 2'b00});
        pwdata <= ($urandom() & 32'hFFFF_F000) | APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        x_setting[3] = POS_W'($urandom_range(1, 4094));
        y_setting[3] = POS_W'($urandom_range(1, 4094));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (opening[i])
            send_byte(opening[i]);
        for (int n = 0; n < PHASE_BYTES; n++)
            send_byte(random_byte());
        for (int s = 0; s < N_SETTINGS; s++)
        begin
            wait_idle();
            write_limit(REG_X_LIMIT, x_setting[s]);
            write_limit(REG_Y_LIMIT, y_setting[s]);
            settings_used++;
            for (int n = 0; n < PHASE_BYTES; n++)
                send_byte(random_byte());
        end
        wait_idle();
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d bytes and %0d packets over %0d limit settings",
                 bytes_seen, packets_seen, settings_used);
        $display("cursor held at zero %0d times and at the limit %0d times",
                 floor_hits, ceil_hits);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### ps2_mouse_packet_cursor.f
rtl/ps2mc_pkg.sv
rtl/ps2mc_front.sv
rtl/ps2mc_fifo.sv
rtl/ps2mc_back.sv
rtl/ps2_mouse_packet_cursor.sv
rtl/ps2mc_checker.sv
tb/ps2mc_checker.sv
tb/tb_ps2_mouse_packet_cursor.sv
